// ----- sv/trapezoid_velocity_limiter_defines.svh -----
// ----------------------------------------------------------------------------
// trapezoid velocity limiter: assertion macros
// property checks for simulation, empty bodies for synthesis
// ----------------------------------------------------------------------------
`ifndef TRAPEZOID_VELOCITY_LIMITER_DEFINES_SVH
`define TRAPEZOID_VELOCITY_LIMITER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define TVL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tvl check failed: same-cycle implication");

// next-cycle implication
`define TVL_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tvl check failed: next-cycle implication");

`else

`define TVL_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define TVL_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- sv/tvl_pkg.sv -----
// ----------------------------------------------------------------------------
// tvl_pkg
// shared widths, register indexes and controller/datapath signal groups
// ----------------------------------------------------------------------------
`default_nettype none

package tvl_pkg;

  // field widths fixed by the stream format
  localparam int SPEED_W     = 24;
  localparam int RATE_W      = 16;
  localparam int SCALE_W     = 16;
  localparam int SCALE_SHIFT = 15;
  localparam int POS_FIELD_W = 32;

  // parameter defaults
  localparam int POS_WIDTH_DEF       = 32;
  localparam int SPEED_FRAC_BITS_DEF = 8;

  // stream packing
  localparam int TGT_LSB    = 0;
  localparam int CUR_LSB    = TGT_LSB + POS_FIELD_W;
  localparam int SCALE_LSB  = CUR_LSB + POS_FIELD_W;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 80;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = SPEED_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE     = 2'd0,
    CFG_ACCEL_STEP = 2'd1,
    CFG_DECEL_RATE = 2'd2,
    CFG_SPEED_MAX  = 2'd3
  } cfg_idx_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic load_err;
    logic load_prod;
    logic root_start;
    logic root_step;
    logic load_speed;
    logic load_lim;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic enable;
    logic root_last;
  } status_t;

endpackage

`default_nettype wire

// ----- sv/tvl_sqrt.sv -----
// ----------------------------------------------------------------------------
// tvl_sqrt
// bit-serial integer square root, one result bit per step, rounded down
// ----------------------------------------------------------------------------
`default_nettype none

module tvl_sqrt #(
  parameter int ROOT_W = 28
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic                  step,
  input  wire logic [2*ROOT_W-1:0]   radicand,
  output logic      [ROOT_W-1:0]     root,
  output logic                       last
);

  localparam int REM_W = ROOT_W + 2;
  localparam int CNT_W = $clog2(ROOT_W);

  logic [2*ROOT_W-1:0] rad;
  logic [REM_W-1:0]    rem;
  logic [ROOT_W-1:0]   q;
  logic [CNT_W-1:0]    cnt;

  logic [REM_W+1:0]    cur;
  logic [REM_W+1:0]    trial;
  logic [REM_W+1:0]    diff;
  logic                ge;

  // bring down the next two radicand bits and try the next root bit
  assign cur   = {rem, rad[2*ROOT_W-1 -: 2]};
  assign trial = (REM_W+2)'({q, 2'b01});
  assign diff  = cur - trial;
  assign ge    = (cur >= trial);

  always_ff @(posedge clk) begin
    if (start) begin
      rad <= radicand;
      rem <= '0;
      q   <= '0;
    end else if (step) begin
      rad <= {rad[2*ROOT_W-3:0], 2'b00};
      rem <= ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
      q   <= {q[ROOT_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(ROOT_W - 1);
    end else if (step && (cnt != '0)) begin
      cnt <= cnt - 1'b1;
    end
  end

  assign root = q;
  assign last = (cnt == '0);

endmodule

`default_nettype wire

// ----- sv/tvl_dp.sv -----
// ----------------------------------------------------------------------------
// tvl_dp
// datapath: registers, error, radicand product, speed select, scaled limit
// ----------------------------------------------------------------------------
`default_nettype none

`include "trapezoid_velocity_limiter_defines.svh"

module tvl_dp import tvl_pkg::*; #(
  parameter int POS_WIDTH       = POS_WIDTH_DEF,
  parameter int SPEED_FRAC_BITS = SPEED_FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cmd_t                  cmd,
  output status_t                    sts,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [IN_DATA_W-1:0]  in_data,
  input  wire logic                  in_user,
  output logic      [OUT_DATA_W-1:0] out_data,
  output logic                       out_user
);

  localparam int ERR_W  = POS_WIDTH - 1;
  localparam int PROD_W = ERR_W + RATE_W;
  localparam int RAD_W  = PROD_W + SPEED_FRAC_BITS + 1;
  localparam int ROOT_W = (RAD_W + 1) / 2;
  localparam int CMP_W  = (ROOT_W > SPEED_W) ? ROOT_W : SPEED_W;
  localparam int LIM_W  = SPEED_W + SCALE_W;

  // configuration registers
  logic                enable;
  logic [RATE_W-1:0]   accel_step;
  logic [RATE_W-1:0]   decel_rate;
  logic [SPEED_W-1:0]  speed_max;

  // profile state
  logic [SPEED_W-1:0]  running_speed;

  // captured word
  logic signed [POS_WIDTH-1:0] tgt;
  logic signed [POS_WIDTH-1:0] cur;
  logic                        brake;
  logic [SCALE_W-1:0]          scale;
  logic                        applied_q;

  // intermediate registers
  logic [ERR_W-1:0]    err_q;
  logic [PROD_W-1:0]   prod_q;
  logic [LIM_W-1:0]    lim_prod;

  // result register
  logic [SPEED_W-1:0]     out_speed;
  logic [SPEED_W-1:0]     out_limit;
  logic [POS_FIELD_W-1:0] out_setpoint;
  logic                   out_applied;

  logic signed [POS_WIDTH:0] diff;
  logic [POS_WIDTH:0]        mag;
  logic [ERR_W-1:0]          err_sat;
  logic [2*ROOT_W-1:0]       radicand;
  logic [ROOT_W-1:0]         root;
  logic                      root_last;
  logic [SPEED_W:0]          v_acc;
  logic [SPEED_W-1:0]        v_cap;
  logic [CMP_W-1:0]          bound;
  logic [SPEED_W-1:0]        speed_new;
  logic [LIM_W-SCALE_SHIFT-1:0] lim_shift;
  logic [SPEED_W-1:0]        lim_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable     <= 1'b1;
      accel_step <= '0;
      decel_rate <= '0;
      speed_max  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ENABLE:     enable     <= cfg_data[0];
        CFG_ACCEL_STEP: accel_step <= cfg_data[RATE_W-1:0];
        CFG_DECEL_RATE: decel_rate <= cfg_data[RATE_W-1:0];
        CFG_SPEED_MAX:  speed_max  <= cfg_data[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // |target - current|, saturated to the error width
  assign diff    = (POS_WIDTH+1)'(tgt) - (POS_WIDTH+1)'(cur);
  assign mag     = diff[POS_WIDTH] ? (POS_WIDTH+1)'(-diff) : (POS_WIDTH+1)'(diff);
  assign err_sat = (mag[POS_WIDTH:ERR_W] != '0) ? {ERR_W{1'b1}} : mag[ERR_W-1:0];

  assign radicand = (2*ROOT_W)'({prod_q, {(SPEED_FRAC_BITS+1){1'b0}}});

  tvl_sqrt #(
    .ROOT_W (ROOT_W)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.root_start),
    .step     (cmd.root_step),
    .radicand (radicand),
    .root     (root),
    .last     (root_last)
  );

  // least of accelerated speed, speed cap and braking bound
  assign v_acc     = (SPEED_W+1)'(running_speed) + (SPEED_W+1)'(accel_step);
  assign v_cap     = ({1'b0, speed_max} < v_acc) ? speed_max : v_acc[SPEED_W-1:0];
  assign bound     = brake ? CMP_W'(root) : CMP_W'(speed_max);
  assign speed_new = (bound < CMP_W'(v_cap)) ? bound[SPEED_W-1:0] : v_cap;

  assign lim_shift = lim_prod[LIM_W-1:SCALE_SHIFT];
  assign lim_sat   = (lim_shift[LIM_W-SCALE_SHIFT-1:SPEED_W] != '0) ? {SPEED_W{1'b1}}
                                                                   : lim_shift[SPEED_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      running_speed <= '0;
    end else if (cmd.load_speed) begin
      running_speed <= speed_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      tgt       <= in_data[TGT_LSB +: POS_WIDTH];
      cur       <= in_data[CUR_LSB +: POS_WIDTH];
      scale     <= in_data[SCALE_LSB +: SCALE_W];
      brake     <= in_user;
      applied_q <= enable;
    end
    if (cmd.load_err) begin
      err_q <= err_sat;
    end
    if (cmd.load_prod) begin
      prod_q <= PROD_W'(err_q) * PROD_W'(decel_rate);
    end
    if (cmd.load_lim) begin
      lim_prod <= LIM_W'(running_speed) * LIM_W'(scale);
    end
    if (cmd.load_out) begin
      out_speed <= running_speed;
      if (applied_q) begin
        out_limit    <= lim_sat;
        out_setpoint <= POS_FIELD_W'(tgt);
        out_applied  <= 1'b1;
      end else begin
        out_limit    <= '0;
        out_setpoint <= '0;
        out_applied  <= 1'b0;
      end
    end
  end

  assign sts      = '{enable: enable, root_last: root_last};
  assign out_data = {out_setpoint, out_limit, out_speed};
  assign out_user = out_applied;

  `TVL_ASSERT_NXT(a_speed_capped, clk, rst, cmd.load_speed, running_speed <= $past(speed_max))
  `TVL_ASSERT_NXT(a_speed_held, clk, rst, !cmd.load_speed, running_speed == $past(running_speed))
  `TVL_ASSERT_NXT(a_disabled_zero, clk, rst, cmd.load_out && !applied_q,
                  (out_limit == '0) && (out_setpoint == '0) && !out_applied)

endmodule

`default_nettype wire

// ----- sv/tvl_ctrl.sv -----
// ----------------------------------------------------------------------------
// tvl_ctrl
// sequencer: input and output handshakes, datapath step commands
// ----------------------------------------------------------------------------
`default_nettype none

`include "trapezoid_velocity_limiter_defines.svh"

module tvl_ctrl import tvl_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    s_tvalid,
  output logic         s_tready,
  output logic         m_tvalid,
  input  wire logic    m_tready,
  input  wire status_t sts,
  output cmd_t         cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_ERR   = 8'b0000_0010,
    S_MULT  = 8'b0000_0100,
    S_START = 8'b0000_1000,
    S_ROOT  = 8'b0001_0000,
    S_SEL   = 8'b0010_0000,
    S_SCALE = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_full;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = sts.enable ? S_ERR : S_OUT;
        end
      end
      S_ERR: begin
        cmd.load_err = 1'b1;
        state_next   = S_MULT;
      end
      S_MULT: begin
        cmd.load_prod = 1'b1;
        state_next    = S_START;
      end
      S_START: begin
        cmd.root_start = 1'b1;
        state_next     = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (sts.root_last) begin
          state_next = S_SEL;
        end
      end
      S_SEL: begin
        cmd.load_speed = 1'b1;
        state_next     = S_SCALE;
      end
      S_SCALE: begin
        cmd.load_lim = 1'b1;
        state_next   = S_OUT;
      end
      S_OUT: begin
        // wait for the result register to free up
        if (!out_full || m_tready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_full <= 1'b1;
      end else if (m_tready) begin
        out_full <= 1'b0;
      end
    end
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_full;

  `TVL_ASSERT_NXT(a_enabled_start, clk, rst, (state == S_IDLE) && s_tvalid && sts.enable, state == S_ERR)
  `TVL_ASSERT_NXT(a_root_exit, clk, rst, (state == S_ROOT) && sts.root_last, state == S_SEL)
  `TVL_ASSERT_NXT(a_result_shown, clk, rst, cmd.load_out, m_tvalid)

endmodule

`default_nettype wire

// ----- sv/trapezoid_velocity_limiter.sv -----
// ----------------------------------------------------------------------------
// trapezoid_velocity_limiter
// per-tick speed limit for a position loop with trapezoidal speed profile
// ----------------------------------------------------------------------------
// Each input word is one control tick. With the profile enabled the running
// speed becomes the least of (old speed + accel_step), speed_max and, when
// braking at the target, floor(sqrt(2 * decel_rate * |error| * 2^frac)),
// with the error saturated to POS_WIDTH-1 bits; otherwise the braking bound
// is speed_max. The result word carries the new speed, the PID output limit
// (speed * speed_scale >> 15, saturated to 24 bits), the target as setpoint
// and applied = 1. Disabled, the block reports the held speed with a zero
// limit, zero setpoint and applied = 0. One word is processed at a time: an
// enabled word steps through error, product, root start, the bit-serial
// square root that resolves one root bit per cycle (ROOT_W = 28 at the
// default widths), speed select, limit scaling and output, and the sequencer
// is back in idle in the same cycle as the result is shown; a disabled word
// goes from acceptance straight to output. A result that waits for the
// output register to free up stalls the sequencer for as long as it waits.
// A new word is accepted as soon as the sequencer is back in idle, even while
// the previous result still waits in the output register. Configuration
// writes should only be issued while no word is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module trapezoid_velocity_limiter import tvl_pkg::*; #(
  parameter int POS_WIDTH       = POS_WIDTH_DEF,       // position bits used
  parameter int SPEED_FRAC_BITS = SPEED_FRAC_BITS_DEF  // fraction bits of speeds
) (
  input  wire logic                  clk,
  input  wire logic                  rst,

  // input word stream
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // target_position [31:0], current_position [63:32], speed_scale [79:64]
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // brake_at_target [0]
  input  wire logic                  s_tuser,

  // result word stream
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // speed [23:0], speed_limit [47:24], setpoint [79:48]
  output logic      [OUT_DATA_W-1:0] m_tdata,
  // applied [0]
  output logic                       m_tuser,

  // configuration writes: 0 enable, 1 accel_step, 2 decel_rate, 3 speed_max
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t    cmd;   // step commands from the sequencer
  status_t sts;   // enable and root-done back to the sequencer

  // sequencer: owns both handshakes
  tvl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: config registers, running speed, root unit, result register
  tvl_dp #(
    .POS_WIDTH       (POS_WIDTH),
    .SPEED_FRAC_BITS (SPEED_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_tdata),
    .in_user   (s_tuser),
    .out_data  (m_tdata),
    .out_user  (m_tuser)
  );

endmodule

`default_nettype wire

// ----- verif/tb_trapezoid_velocity_limiter.sv -----
`timescale 1ns / 100ps

// ----------------------------------------------------------------------------
// tb_trapezoid_velocity_limiter
// ----------------------------------------------------------------------------
// Drives control ticks into the velocity limiter and checks every result word
// against a cycle-free model of the profile: the running speed steps up by
// accel_step, is clipped by speed_max and, when braking, by the stopping
// distance root; the limit is the speed scaled by the Q1.15 coefficient.
// A short directed run covers the field extremes, error saturation, the
// disabled state and the scale above unity; random phases follow, each with
// fresh register settings, approach sequences toward a target and random
// idling on both streams.
// ----------------------------------------------------------------------------

module tb_trapezoid_velocity_limiter;
  import tvl_pkg::*;

  localparam int QUIET_LIMIT   = 1000;  // cycles without a handshake before giving up
  localparam int RANDOM_PHASES = 10;
  localparam int SETTLE_CYCLES = 40;    // a little more than one enabled word

  // one result word, unpacked
  typedef struct packed {
    logic [23:0] speed;
    logic [23:0] limit;
    logic [31:0] setpoint;
    logic        applied;
  } limit_word_t;

  // profile model with its own register copy and the queue of awaited words
  class speed_limit_tracker;
    bit          enable;
    bit   [15:0] accel_step;
    bit   [15:0] decel_rate;
    bit   [23:0] speed_max;
    bit   [23:0] running_speed;
    limit_word_t awaited[$];
    int          errors;

    function new();
      enable        = 1'b1;
      accel_step    = '0;
      decel_rate    = '0;
      speed_max     = '0;
      running_speed = '0;
      errors        = 0;
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= 200) $display("%0t mismatch: %s", $time, msg);
    endtask

    function void set_reg(input cfg_idx_t idx, input bit [23:0] value);
      case (idx)
        CFG_ENABLE:     enable     = value[0];
        CFG_ACCEL_STEP: accel_step = value[15:0];
        CFG_DECEL_RATE: decel_rate = value[15:0];
        CFG_SPEED_MAX:  speed_max  = value;
        default: ;
      endcase
    endfunction

    // integer square root, rounded down; radicand stays below 2^57
    function bit [63:0] floor_root(input bit [63:0] x);
      bit [63:0] r;
      bit [63:0] trial;
      r = '0;
      for (int b = 29; b >= 0; b--) begin
        trial = r | (64'd1 << b);
        if (trial * trial <= x) r = trial;
      end
      return r;
    endfunction

    // accepted tick: advance the speed and queue the word it must produce
    function void note_tick(input logic [31:0] tgt, input logic [31:0] cur,
                            input bit brake, input bit [15:0] scale);
      limit_word_t      w;
      logic signed [32:0] diff;
      bit   [32:0]      err;
      bit   [63:0]      radicand;
      bit   [63:0]      brake_bound;
      bit   [63:0]      v;
      bit   [39:0]      prod;
      if (!enable) begin
        w.speed    = running_speed;
        w.limit    = '0;
        w.setpoint = '0;
        w.applied  = 1'b0;
        awaited.push_back(w);
        return;
      end
      if (brake) begin
        diff = {tgt[31], tgt} - {cur[31], cur};
        err  = (diff < 0) ? -diff : diff;
        // error saturates to 31 bits before the root
        if (err > 33'h0_7FFF_FFFF) err = 33'h0_7FFF_FFFF;
        radicand    = ((64'(decel_rate) * 2) * 64'(err)) << 8;
        brake_bound = floor_root(radicand);
      end else begin
        brake_bound = 64'(speed_max);
      end
      v = 64'(running_speed) + 64'(accel_step);
      if (64'(speed_max) < v) v = 64'(speed_max);
      if (brake_bound < v) v = brake_bound;
      running_speed = v[23:0];
      prod = 40'(running_speed) * 40'(scale);
      w.speed    = running_speed;
      w.limit    = ((prod >> 15) > 40'hFF_FFFF) ? 24'hFF_FFFF : prod[38:15];
      w.setpoint = tgt;
      w.applied  = 1'b1;
      awaited.push_back(w);
    endfunction

    function int backlog();
      return awaited.size();
    endfunction

    task check_word(input logic [OUT_DATA_W-1:0] data, input logic applied);
      limit_word_t got;
      limit_word_t want;
      got.speed    = data[23:0];
      got.limit    = data[47:24];
      got.setpoint = data[79:48];
      got.applied  = applied;
      if (awaited.size() == 0) begin
        report($sformatf("result word %h with nothing awaited", data));
        return;
      end
      want = awaited.pop_front();
      if (got.speed !== want.speed)
        report($sformatf("speed %h, awaited %h", got.speed, want.speed));
      if (got.limit !== want.limit)
        report($sformatf("speed_limit %h, awaited %h", got.limit, want.limit));
      if (got.setpoint !== want.setpoint)
        report($sformatf("setpoint %h, awaited %h", got.setpoint, want.setpoint));
      if (got.applied !== want.applied)
        report($sformatf("applied %b, awaited %b", got.applied, want.applied));
    endtask

    task close_out();
      while (awaited.size() != 0) begin
        void'(awaited.pop_front());
        report("awaited word never arrived");
      end
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // target [31:0], current [63:32], scale [79:64]
  logic                  s_tuser;   // brake_at_target [0]
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // speed [23:0], speed_limit [47:24], setpoint [79:48]
  logic                  m_tuser;   // applied [0]
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  speed_limit_tracker tracker;
  bit                 steady;       // phase without idling on either side
  int                 quiet;

  // state of the current approach toward a fixed target
  logic [31:0]        approach_tgt;
  int unsigned        approach_gap;
  bit                 approach_above;

  trapezoid_velocity_limiter i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: any stretch without a handshake on either stream ends the run
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // result side: random stall before each word, then check it on acceptance
  initial begin : result_sink
    int stall;
    m_tready = 1'b0;
    do @(negedge clk); while (rst);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      tracker.check_word(m_tdata, m_tuser);
      @(negedge clk);
    end
  end

  // entered and left at a falling edge; tvalid stays up for a back-to-back word
  task automatic send_tick(input logic [31:0] tgt, input logic [31:0] cur,
                           input bit brake, input bit [15:0] scale);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {scale, cur, tgt};
    s_tuser  <= brake;
    do @(posedge clk); while (!s_tready);
    tracker.note_tick(tgt, cur, brake, scale);
    @(negedge clk);
  endtask

  // hold off the sender until every awaited word has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (tracker.backlog() != 0);
  endtask

  // only called with the block idle
  task automatic write_reg(input cfg_idx_t idx, input logic [23:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    tracker.set_reg(idx, value);
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_profile(input logic [23:0] en, input logic [23:0] accel,
                              input logic [23:0] decel, input logic [23:0] vmax);
    write_reg(CFG_ENABLE, en);
    write_reg(CFG_ACCEL_STEP, accel);
    write_reg(CFG_DECEL_RATE, decel);
    write_reg(CFG_SPEED_MAX, vmax);
  endtask

  // rate register value; upper bits carry noise the block must ignore
  function automatic logic [23:0] pick_rate();
    case ($urandom_range(0, 4))
      0:       return 24'h0;
      1:       return {8'($urandom), 16'hFFFF};
      2:       return 24'($urandom);
      default: return 24'($urandom_range(1, 16'h0400));
    endcase
  endfunction

  function automatic logic [23:0] pick_top_speed();
    case ($urandom_range(0, 4))
      0:       return 24'h0;
      1:       return 24'hFF_FFFF;
      2:       return 24'($urandom);
      default: return 24'($urandom_range(16'h0100, 24'h04_0000));
    endcase
  endfunction

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(0, 4))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0;
      3:       return 32'hFFFF_FFFF;
      default: return 32'h1;
    endcase
  endfunction

  task automatic random_tick(input int brake_pct);
    logic [31:0] tgt;
    logic [31:0] cur;
    bit          brake;
    bit   [15:0] scale;
    case ($urandom_range(0, 5))
      0, 1, 2: begin
        // closing in on a target, the error shrinking tick by tick
        if (approach_gap == 0) begin
          approach_tgt   = $urandom();
          approach_gap   = $urandom_range(1, 1 << $urandom_range(2, 24));
          approach_above = $urandom_range(0, 1);
        end else begin
          approach_gap = approach_gap - $urandom_range(0, approach_gap / 8 + 1);
        end
        tgt = approach_tgt;
        cur = approach_above ? tgt + approach_gap : tgt - approach_gap;
      end
      3: begin
        cur = $urandom();
        tgt = cur + $urandom_range(0, 4000) - 32'd2000;
      end
      4: begin
        tgt = $urandom();
        cur = $urandom();
      end
      default: begin
        tgt = pick_extreme();
        cur = pick_extreme();
      end
    endcase
    brake = $urandom_range(0, 99) < brake_pct;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: scale = 16'h8000;
      4, 5:       scale = 16'($urandom);
      6:          scale = 16'hFFFF;
      7:          scale = 16'h0;
      default:    scale = 16'($urandom_range(0, 32768));
    endcase
    send_tick(tgt, cur, brake, scale);
  endtask

  initial begin : stimulus
    int ticks;
    int brake_pct;
    tracker        = new();
    steady         = 1'b0;
    approach_gap   = 0;
    approach_tgt   = '0;
    approach_above = 1'b0;
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_ENABLE;
    cfg_data       = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: enabled, every rate and the top speed at zero
    send_tick(32'd5, 32'd0, 1'b0, 16'h8000);
    send_tick(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 16'hFFFF);
    drain();

    // modest profile: ramp, zero error, tiny errors of both signs, saturation
    load_profile(24'd1, 24'h0180, 24'h0100, 24'h00_1000);
    send_tick(32'd1000, 32'd0, 1'b0, 16'h8000);
    send_tick(-32'sd1000, 32'd0, 1'b0, 16'h4000);
    send_tick(32'd7, 32'd7, 1'b1, 16'h8000);
    send_tick(32'd3, 32'd0, 1'b1, 16'h8000);
    send_tick(32'hFFFF_FFFF, 32'd1, 1'b1, 16'hFFFF);
    send_tick(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 16'h0);
    send_tick(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 16'h8001);
    send_tick(32'd0, 32'd0, 1'b0, 16'hFFFF);
    // climb into the top speed
    repeat (6) send_tick($urandom(), $urandom(), 1'b0, 16'h8000);
    drain();

    // disabled: speed held, everything else zero
    write_reg(CFG_ENABLE, 24'h0);
    send_tick(32'h1234_5678, 32'h0, 1'b1, 16'hFFFF);
    send_tick(32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 16'h8000);
    drain();

    // every register at its top
    load_profile(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
    send_tick(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 16'hFFFF);
    send_tick(32'h1234_5678, 32'h1234_5677, 1'b1, 16'h8000);
    drain();

    // every rate at zero
    load_profile(24'd1, 24'h0, 24'h0, 24'h0);
    send_tick(32'd100, 32'd0, 1'b0, 16'hFFFF);
    send_tick(32'd100, 32'd0, 1'b1, 16'hFFFF);
    drain();

    // random phases; the first runs flat out so the limit saturates
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0) begin
        load_profile(24'd1, 24'hFFFF, 24'hFFFF, 24'hFF_FFFF);
        brake_pct = 0;
        ticks     = 200;
        steady    = 1'b0;
      end else begin
        load_profile({23'($urandom), 1'($urandom_range(0, 5) != 0)},
                     pick_rate(), pick_rate(), pick_top_speed());
        case ($urandom_range(0, 2))
          0:       brake_pct = 10;
          1:       brake_pct = 60;
          default: brake_pct = 90;
        endcase
        ticks  = 100;
        steady = ($urandom_range(0, 3) == 0);
      end
      for (int n = 0; n < ticks; n++) begin
        random_tick(brake_pct);
        if ($urandom_range(0, 39) == 0) drain();
      end
      drain();
    end

    // all words back; give a stray word time to show up
    steady = 1'b0;
    repeat (SETTLE_CYCLES) @(negedge clk);
    tracker.close_out();
    if (tracker.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/tvl_pkg.sv
sv/tvl_sqrt.sv
sv/tvl_dp.sv
sv/tvl_ctrl.sv
sv/trapezoid_velocity_limiter.sv
verif/tb_trapezoid_velocity_limiter.sv
